/* rtl/tblp_pkg.sv */
// Shared constants and types for the three-axis biquad low-pass unit.
// Used by the lane, the merge stage and the top level; depends on nothing else.
package tblp_pkg;

   // Number format and field widths.
   localparam int COEF_FRAC_BITS = 29;
   localparam int OUT_FRAC_BITS  = 8;
   localparam int AXES           = 3;
   localparam int SAMPLE_W       = 16;
   localparam int COEF_W         = 32;
   localparam int OUT_W          = 32;

   // Datapath widths derived from the field widths.
   localparam int PROD_W  = COEF_W + SAMPLE_W;
   localparam int FF_W    = PROD_W + 2;
   localparam int FB_W    = COEF_W + OUT_W;
   localparam int ACC_W   = ((FF_W + OUT_FRAC_BITS) > FB_W) ?
                            (FF_W + OUT_FRAC_BITS + 2) : (FB_W + 2);
   localparam int QUO_W   = ACC_W - COEF_FRAC_BITS;
   localparam int REQ_W   = AXES * SAMPLE_W;
   localparam int RSP_W   = AXES * OUT_W;

   // Register file indexes.
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_B0  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_B1  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_B2  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_A1  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_A2  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_X = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_Y = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_Z = 3'd7;

   // Register reset values.
   localparam logic signed [COEF_W-1:0] RST_COEF_B0 = 32'sd70387234;
   localparam logic signed [COEF_W-1:0] RST_COEF_B1 = 32'sd140774468;
   localparam logic signed [COEF_W-1:0] RST_COEF_B2 = 32'sd70387234;
   localparam logic signed [COEF_W-1:0] RST_COEF_A1 = -32'sd401466258;
   localparam logic signed [COEF_W-1:0] RST_COEF_A2 = 32'sd146144282;

   // Filter coefficient set shared by all lanes.
   typedef struct packed {
      logic signed [COEF_W-1:0] b0;
      logic signed [COEF_W-1:0] b1;
      logic signed [COEF_W-1:0] b2;
      logic signed [COEF_W-1:0] a1;
      logic signed [COEF_W-1:0] a2;
   } coef_type;

   // Per-stage load strobes driven by the pipeline control.
   typedef struct packed {
      logic ld_a;
      logic ld_b;
      logic ld_c;
      logic ld_d;
   } stage_ctl_type;

endpackage

/* rtl/tblp_lane.sv */
// One axis of the filter: offset removal, feed-forward products, sum, feedback loop.
// Depends on tblp_pkg for widths and the coefficient and strobe types.
module tblp_lane (
   input  logic                                    clock,
   input  logic                                    reset,
   input  tblp_pkg::stage_ctl_type                 ctl,
   input  logic signed [tblp_pkg::SAMPLE_W-1:0]    sample,
   input  logic signed [tblp_pkg::SAMPLE_W-1:0]    offset,
   input  tblp_pkg::coef_type                      coef,
   input  logic signed [tblp_pkg::COEF_W-1:0]      coef_a2_next,
   output logic signed [tblp_pkg::OUT_W-1:0]       filtered
);
   import tblp_pkg::*;

   localparam logic signed [ACC_W-1:0] ROUND_CONST = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
   localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};
   localparam logic signed [SAMPLE_W-1:0] SMP_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] SMP_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   logic signed [SAMPLE_W:0]   diff;
   logic signed [SAMPLE_W-1:0] dsat;
   logic signed [SAMPLE_W-1:0] tap0_ff, tap1_ff, tap2_ff;
   logic signed [PROD_W-1:0]   p0_ff, p1_ff, p2_ff;
   logic signed [PROD_W-1:0]   p0_in, p1_in, p2_in;
   logic signed [FF_W-1:0]     ff_sum;
   logic signed [ACC_W-1:0]    ffs_ff, ffs_in;
   logic signed [FB_W-1:0]     fb1;
   logic signed [FB_W-1:0]     a2prod_ff, a2prod_in;
   logic signed [OUT_W-1:0]    y2_next;
   logic signed [ACC_W-1:0]    acc;
   logic signed [QUO_W-1:0]    quo;
   logic signed [OUT_W-1:0]    y_ff, y_in, y2_ff;

   // Stage A: remove the offset and clamp the difference to the sample range.
   always_comb begin
      diff = {sample[SAMPLE_W-1], sample} - {offset[SAMPLE_W-1], offset};
      if (diff[SAMPLE_W] != diff[SAMPLE_W-1]) begin
         dsat = diff[SAMPLE_W] ? SMP_MIN : SMP_MAX;
      end else begin
         dsat = diff[SAMPLE_W-1:0];
      end
   end

   // The tap line holds this request's input and the two before it.
   always_ff @(posedge clock) begin
      if (reset) begin
         tap0_ff <= '0;
         tap1_ff <= '0;
         tap2_ff <= '0;
      end else if (ctl.ld_a) begin
         tap0_ff <= dsat;
         tap1_ff <= tap0_ff;
         tap2_ff <= tap1_ff;
      end
   end

   // Stage B: the three feed-forward products.
   always_comb begin
      p0_in = PROD_W'(coef.b0) * PROD_W'(tap0_ff);
      p1_in = PROD_W'(coef.b1) * PROD_W'(tap1_ff);
      p2_in = PROD_W'(coef.b2) * PROD_W'(tap2_ff);
   end

   always_ff @(posedge clock) begin
      if (ctl.ld_b) begin
         p0_ff <= p0_in;
         p1_ff <= p1_in;
         p2_ff <= p2_in;
      end
   end

   // Stage C: feed-forward sum, scaled to the output format, with the rounding bias.
   always_comb begin
      ff_sum = {{(FF_W-PROD_W){p0_ff[PROD_W-1]}}, p0_ff}
             + {{(FF_W-PROD_W){p1_ff[PROD_W-1]}}, p1_ff}
             + {{(FF_W-PROD_W){p2_ff[PROD_W-1]}}, p2_ff};
      ffs_in = ({{(ACC_W-FF_W){ff_sum[FF_W-1]}}, ff_sum} <<< OUT_FRAC_BITS) + ROUND_CONST;
   end

   always_ff @(posedge clock) begin
      if (ctl.ld_c) begin
         ffs_ff <= ffs_in;
      end
   end

   // The older feedback product is registered from the next values of the second
   // output tap and of the coefficient, so it always matches them.
   always_comb begin
      y2_next   = ctl.ld_d ? y_ff : y2_ff;
      a2prod_in = FB_W'(coef_a2_next) * FB_W'(y2_next);
   end

   // Stage D: feedback loop, rounding shift and output clamp.
   always_comb begin
      fb1 = FB_W'(coef.a1) * FB_W'(y_ff);
      acc = ffs_ff
          - {{(ACC_W-FB_W){fb1[FB_W-1]}}, fb1}
          - {{(ACC_W-FB_W){a2prod_ff[FB_W-1]}}, a2prod_ff};
      quo = acc[ACC_W-1:COEF_FRAC_BITS];
      if ((&quo[QUO_W-1:OUT_W-1]) || !(|quo[QUO_W-1:OUT_W-1])) begin
         y_in = quo[OUT_W-1:0];
      end else begin
         y_in = quo[QUO_W-1] ? OUT_MIN : OUT_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         y_ff      <= '0;
         y2_ff     <= '0;
         a2prod_ff <= '0;
      end else begin
         a2prod_ff <= a2prod_in;
         if (ctl.ld_d) begin
            y_ff  <= y_in;
            y2_ff <= y_ff;
         end
      end
   end

   assign filtered = y_ff;

endmodule

/* rtl/tblp_merge.sv */
// Output register that joins the three lane results into one response.
// Depends on tblp_pkg for widths.
module tblp_merge (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 lane_valid,
   input  logic signed [tblp_pkg::OUT_W-1:0]    lane_y [tblp_pkg::AXES],
   output logic                                 take,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // Fields from bit 0 up: filtered_x, filtered_y, filtered_z.
   output logic [tblp_pkg::RSP_W-1:0]           rsp_tdata
);
   import tblp_pkg::*;

   logic             valid_ff, valid_in;
   logic [RSP_W-1:0] data_ff, data_in;

   // The register is free when empty or when its response leaves this cycle.
   assign take = !valid_ff || rsp_tready;

   always_comb begin
      for (int k = 0; k < AXES; k++) begin
         data_in[k*OUT_W +: OUT_W] = lane_y[k];
      end
      valid_in = take ? lane_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && lane_valid) begin
         data_ff <= data_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

/* rtl/three_axis_biquad_lowpass_unit.sv */
// Top level of the three-axis biquad low-pass unit: registers, pipeline control,
// three filter lanes and the merge stage. Depends on tblp_pkg, tblp_lane, tblp_merge.
//
//   Channel  Direction  Handshake              Payload
//   req_     in         req_tvalid/req_tready  req_tdata: sample_x, sample_y, sample_z
//   rsp_     out        rsp_tvalid/rsp_tready  rsp_tdata: filtered_x, filtered_y, filtered_z
//   csr_     in         csr_we                 csr_index, csr_wdata
//
// One request per cycle is accepted when nothing stalls; each response passes the offset,
// products, sum, feedback and output registers in that order after its request.
// The feedback stage closes the recursion around its own output register, which sets the rate.
// Reset is synchronous: filter history clears and registers return to defaults.
// Stages move independently, so bubbles are squeezed out and requests are still
// taken while a finished response waits at the output.
module three_axis_biquad_lowpass_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // Fields from bit 0 up: sample_x, sample_y, sample_z.
   input  logic [tblp_pkg::REQ_W-1:0]             req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // Fields from bit 0 up: filtered_x, filtered_y, filtered_z.
   output logic [tblp_pkg::RSP_W-1:0]             rsp_tdata,
   input  logic                                   csr_we,
   input  logic [tblp_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [tblp_pkg::COEF_W-1:0]            csr_wdata
);
   import tblp_pkg::*;

   coef_type                   coef_ff, coef_in;
   logic signed [SAMPLE_W-1:0] offset_ff [AXES];
   logic signed [SAMPLE_W-1:0] offset_in [AXES];
   logic                       va_ff, vb_ff, vc_ff, vd_ff;
   logic                       rdy_a, rdy_b, rdy_c, rdy_d, rdy_out;
   stage_ctl_type              ctl;
   logic signed [OUT_W-1:0]    lane_y [AXES];

   // Register writes.
   always_comb begin
      coef_in = coef_ff;
      for (int k = 0; k < AXES; k++) begin
         offset_in[k] = offset_ff[k];
      end
      if (csr_we) begin
         case (csr_index)
            CSR_COEF_B0:  coef_in.b0   = csr_wdata;
            CSR_COEF_B1:  coef_in.b1   = csr_wdata;
            CSR_COEF_B2:  coef_in.b2   = csr_wdata;
            CSR_COEF_A1:  coef_in.a1   = csr_wdata;
            CSR_COEF_A2:  coef_in.a2   = csr_wdata;
            CSR_OFFSET_X: offset_in[0] = csr_wdata[SAMPLE_W-1:0];
            CSR_OFFSET_Y: offset_in[1] = csr_wdata[SAMPLE_W-1:0];
            CSR_OFFSET_Z: offset_in[2] = csr_wdata[SAMPLE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.b0 <= RST_COEF_B0;
         coef_ff.b1 <= RST_COEF_B1;
         coef_ff.b2 <= RST_COEF_B2;
         coef_ff.a1 <= RST_COEF_A1;
         coef_ff.a2 <= RST_COEF_A2;
         for (int k = 0; k < AXES; k++) begin
            offset_ff[k] <= '0;
         end
      end else begin
         coef_ff <= coef_in;
         for (int k = 0; k < AXES; k++) begin
            offset_ff[k] <= offset_in[k];
         end
      end
   end

   // Ready ripples back: a stage can load when empty or when it empties this cycle.
   assign rdy_d      = !vd_ff || rdy_out;
   assign rdy_c      = !vc_ff || rdy_d;
   assign rdy_b      = !vb_ff || rdy_c;
   assign rdy_a      = !va_ff || rdy_b;
   assign req_tready = rdy_a;

   assign ctl.ld_a = req_tvalid && rdy_a;
   assign ctl.ld_b = va_ff && rdy_b;
   assign ctl.ld_c = vb_ff && rdy_c;
   assign ctl.ld_d = vc_ff && rdy_d;

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else begin
         if (rdy_a) va_ff <= req_tvalid;
         if (rdy_b) vb_ff <= va_ff;
         if (rdy_c) vc_ff <= vb_ff;
         if (rdy_d) vd_ff <= vc_ff;
      end
   end

   // One filter lane per axis.
   for (genvar k = 0; k < AXES; k++) begin : g_lane
      tblp_lane u_lane (
         .clock        (clock),
         .reset        (reset),
         .ctl          (ctl),
         .sample       (req_tdata[k*SAMPLE_W +: SAMPLE_W]),
         .offset       (offset_ff[k]),
         .coef         (coef_ff),
         .coef_a2_next (coef_in.a2),
         .filtered     (lane_y[k])
      );
   end

   // Joined response register.
   tblp_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .lane_valid (vd_ff),
      .lane_y     (lane_y),
      .take       (rdy_out),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Input back-pressure only when every stage is full and the output is blocked.
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (va_ff && vb_ff && vc_ff && vd_ff && rsp_tvalid && !rsp_tready))
      else $error("request refused while the pipeline has room");

   // A finished lane result waits in the feedback stage while the output is blocked.
   a_hold_d: assert property (@(posedge clock) disable iff (reset)
      (vd_ff && rsp_tvalid && !rsp_tready) |=> vd_ff)
      else $error("feedback stage result lost under stall");

   // A result handed to the output register is presented the next cycle.
   a_hand_off: assert property (@(posedge clock) disable iff (reset)
      (vd_ff && rdy_out) |=> rsp_tvalid)
      else $error("result handed off but no response shown");

   // The feedback state moves only when a result enters the feedback stage.
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !ctl.ld_d |=> $stable(lane_y[0]) && $stable(lane_y[1]) && $stable(lane_y[2]))
      else $error("filter output state changed without a request");

endmodule
